// File: src/imu_scan_batcher_unit_macros.svh
// Assertion macros used by the scan batcher checker.
`ifndef IMU_SCAN_BATCHER_UNIT_MACROS_SVH
`define IMU_SCAN_BATCHER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define ISB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("isb check failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define ISB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("isb check failed");

`endif

// File: src/isb_pkg.sv
// Types and constants shared by the scan batcher modules.
`timescale 1ns / 1ps
`default_nettype none
package isb_pkg;

    localparam int ALU_W      = 66;
    localparam int T_W        = 54;
    localparam int NOW_W      = 63;
    localparam int REM_W      = 10;
    localparam int DIVISOR    = 1000;
    localparam int DIV_W      = 64;
    localparam int CHUNK_W    = 16;
    localparam int DIV_CHUNKS = DIV_W / CHUNK_W;
    localparam int X_W        = REM_W + CHUNK_W;
    // floor(x / 1000) == (x * RECIP) >> RECIP_SH for every x below 2^26
    localparam int RECIP_W    = 27;
    localparam int RECIP_SH   = 36;
    localparam logic [RECIP_W-1:0] RECIP = 27'd68719477;
    localparam int PROD_W     = X_W + RECIP_W;
    localparam int CFG_W      = 27;

    localparam logic [1:0] CFG_INTERVAL  = 2'd0;
    localparam logic [1:0] CFG_TOLERANCE = 2'd1;
    localparam logic [1:0] CFG_FUTURE    = 2'd2;
    localparam logic [1:0] CFG_STALE     = 2'd3;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
    } t_scan;

    typedef struct packed {
        logic                    sub;
        logic signed [ALU_W-1:0] a;
        logic signed [ALU_W-1:0] b;
    } t_alu_req;

    typedef enum logic [10:0] {
        ST_IDLE      = 11'b000_0000_0001,
        ST_DIV       = 11'b000_0000_0010,
        ST_FUT_SUM   = 11'b000_0000_0100,
        ST_FUT_CMP   = 11'b000_0000_1000,
        ST_STALE_SUM = 11'b000_0001_0000,
        ST_STALE_CMP = 11'b000_0010_0000,
        ST_GAP_D     = 11'b000_0100_0000,
        ST_GAP_LO    = 11'b000_1000_0000,
        ST_GAP_HI    = 11'b001_0000_0000,
        ST_STORE     = 11'b010_0000_0000,
        ST_EMIT      = 11'b100_0000_0000
    } t_state;

endpackage
`default_nettype wire

// File: src/isb_alu.sv
// Shared 66-bit add/subtract unit used by the divide, window and gap steps of the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module isb_alu
    import isb_pkg::*;
(
    input  wire t_alu_req          i_req,
    output logic signed [ALU_W-1:0] o_sum
);

    logic signed [ALU_W-1:0] b_op;

    always_comb begin
        b_op  = i_req.sub ? ~i_req.b : i_req.b;
        o_sum = i_req.a + b_op + ALU_W'(i_req.sub);
    end

endmodule
`default_nettype wire

// File: src/imu_scan_batcher_unit.sv
// Scan batcher top level: timestamp checks, batch store and result emission.
// A good stamp runs divide, window checks, gap checks and store; a bad stamp is counted in idle.
// Divide by 1000: four 16-bit chunks, reciprocal multiply then remainder on the shared ALU.
// A full batch then emits its BATCH_SIZE results, holding while results are stalled.
// New requests stall until the scan, and the emission of any completed batch, is done.
// Reset (synchronous, active low) clears the batch, last time and error count, and sets config to defaults.
`timescale 1ns / 1ps
`default_nettype none
module imu_scan_batcher_unit
    import isb_pkg::*;
#(
    parameter int BATCH_SIZE = 2
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire [1:0]          i_cfg_index,
    input  wire [CFG_W-1:0]    i_cfg_data,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire signed [15:0]  i_accel_x,
    input  wire signed [15:0]  i_accel_y,
    input  wire signed [15:0]  i_accel_z,
    input  wire signed [15:0]  i_gyro_x,
    input  wire signed [15:0]  i_gyro_y,
    input  wire signed [15:0]  i_gyro_z,
    input  wire signed [63:0]  i_stamp_ns,
    input  wire [NOW_W-1:0]    i_now_us,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic signed [15:0] o_out_accel_x,
    output logic signed [15:0] o_out_accel_y,
    output logic signed [15:0] o_out_accel_z,
    output logic signed [15:0] o_out_gyro_x,
    output logic signed [15:0] o_out_gyro_y,
    output logic signed [15:0] o_out_gyro_z,
    output logic [NOW_W-1:0]   o_batch_time_us,
    output logic [4:0]         o_sample_index,
    output logic [5:0]         o_batch_count,
    output logic [31:0]        o_error_total,
    output logic               o_last
);

    localparam int CW = $clog2(BATCH_SIZE + 1);
    localparam int IW = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1;

    t_state r_state, n_state;
    logic [5:0]              r_cnt, n_cnt;
    logic [CW-1:0]           r_pending, n_pending;
    logic [CW-1:0]           r_emit, n_emit;
    logic [T_W-1:0]          r_last_t, n_last_t;
    logic [31:0]             r_err, n_err;
    logic                    r_gap_fail, n_gap_fail;
    logic                    r_out_valid, n_out_valid;
    logic [15:0]             r_interval;
    logic [15:0]             r_tolerance;
    logic [19:0]             r_future;
    logic [26:0]             r_stale;

    logic [DIV_W-1:0]        r_quo, n_quo;
    logic [REM_W-1:0]        r_rem, n_rem;
    logic [CHUNK_W-1:0]      r_qd, n_qd;
    logic signed [ALU_W-1:0] r_acc, n_acc;
    logic [NOW_W-1:0]        r_now;
    t_scan                   r_smp;
    t_scan                   r_store [BATCH_SIZE];
    t_scan                   r_o_scan;
    logic [NOW_W-1:0]        r_o_time;
    logic [4:0]              r_o_idx;
    logic [31:0]             r_o_err;
    logic                    r_o_last;

    t_alu_req                alu_req;
    logic signed [ALU_W-1:0] alu_sum;
    logic                    alu_neg;
    logic [X_W-1:0]          div_x;
    logic [PROD_W-1:0]       div_prod;
    logic [T_W-1:0]          t_us;
    logic signed [16:0]      lo_bound;
    logic [16:0]             hi_bound;
    logic [31:0]             err_inc;
    logic                    in_acc;
    logic                    stamp_bad;
    logic                    out_load;
    logic                    store_we;
    logic [IW-1:0]           wr_idx;
    logic [CW-1:0]           fill;

    isb_alu u_alu (
        .i_req (alu_req),
        .o_sum (alu_sum)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign stamp_bad  = (i_stamp_ns == 64'sd0) || i_stamp_ns[63];
    assign alu_neg    = alu_sum[ALU_W-1];
    assign div_x      = {r_rem, r_quo[DIV_W-1 -: CHUNK_W]};
    assign div_prod   = PROD_W'(div_x) * PROD_W'(RECIP);
    assign t_us       = r_quo[T_W-1:0];
    assign lo_bound   = $signed({1'b0, r_interval}) - $signed({1'b0, r_tolerance});
    assign hi_bound   = {1'b0, r_interval} + {1'b0, r_tolerance};
    assign err_inc    = (r_err == '1) ? r_err : r_err + 32'd1;
    assign wr_idx     = r_gap_fail ? '0 : r_pending[IW-1:0];
    assign fill       = (r_gap_fail ? '0 : r_pending) + CW'(1);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pending   = r_pending;
        n_emit      = r_emit;
        n_last_t    = r_last_t;
        n_err       = r_err;
        n_gap_fail  = r_gap_fail;
        n_out_valid = r_out_valid;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_qd        = r_qd;
        n_acc       = r_acc;
        alu_req     = '{sub: 1'b1, a: '0, b: '0};
        out_load    = 1'b0;
        store_we    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (stamp_bad) begin
                        n_err     = err_inc;
                        n_pending = '0;
                    end else begin
                        n_quo   = $unsigned(i_stamp_ns);
                        n_rem   = '0;
                        n_cnt   = '0;
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                n_cnt = r_cnt + 6'd1;
                if (!r_cnt[0]) begin
                    n_qd = div_prod[RECIP_SH +: CHUNK_W];
                end else begin
                    alu_req.a = ALU_W'(div_x);
                    alu_req.b = ALU_W'(X_W'(r_qd) * X_W'(DIVISOR));
                    n_rem     = alu_sum[REM_W-1:0];
                    n_quo     = {r_quo[DIV_W-CHUNK_W-1:0], r_qd};
                end
                if (r_cnt == 6'(2 * DIV_CHUNKS - 1)) begin
                    n_state = ST_FUT_SUM;
                end
            end
            ST_FUT_SUM: begin
                alu_req.sub = 1'b0;
                alu_req.a   = ALU_W'(r_now);
                alu_req.b   = ALU_W'(r_future);
                n_acc       = alu_sum;
                n_state     = ST_FUT_CMP;
            end
            ST_FUT_CMP: begin
                alu_req.a = r_acc;
                alu_req.b = ALU_W'(t_us);
                if (alu_neg) begin
                    n_err     = err_inc;
                    n_pending = '0;
                    n_last_t  = t_us;
                    n_state   = ST_IDLE;
                end else begin
                    n_state = ST_STALE_SUM;
                end
            end
            ST_STALE_SUM: begin
                alu_req.sub = 1'b0;
                alu_req.a   = ALU_W'(t_us);
                alu_req.b   = ALU_W'(r_stale);
                n_acc       = alu_sum;
                n_state     = ST_STALE_CMP;
            end
            ST_STALE_CMP: begin
                alu_req.a = r_acc;
                alu_req.b = ALU_W'(r_now);
                if (alu_neg) begin
                    n_err     = err_inc;
                    n_pending = '0;
                    n_last_t  = t_us;
                    n_state   = ST_IDLE;
                end else begin
                    n_state = ST_GAP_D;
                end
            end
            ST_GAP_D: begin
                alu_req.a  = ALU_W'(t_us);
                alu_req.b  = ALU_W'(r_last_t);
                n_acc      = alu_sum;
                n_gap_fail = 1'b0;
                n_state    = (r_last_t == '0) ? ST_STORE : ST_GAP_LO;
            end
            ST_GAP_LO: begin
                alu_req.a = r_acc;
                alu_req.b = ALU_W'(lo_bound);
                if (alu_neg) begin
                    n_gap_fail = 1'b1;
                end
                n_state = ST_GAP_HI;
            end
            ST_GAP_HI: begin
                alu_req.a = ALU_W'(hi_bound);
                alu_req.b = r_acc;
                if (alu_neg) begin
                    n_gap_fail = 1'b1;
                end
                n_state = ST_STORE;
            end
            ST_STORE: begin
                store_we = 1'b1;
                n_last_t = t_us;
                if (r_gap_fail) begin
                    n_err = err_inc;
                end
                if (fill == CW'(BATCH_SIZE)) begin
                    n_pending = '0;
                    n_emit    = '0;
                    n_state   = ST_EMIT;
                end else begin
                    n_pending = fill;
                    n_state   = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    if (r_emit != CW'(BATCH_SIZE)) begin
                        out_load    = 1'b1;
                        n_out_valid = 1'b1;
                        n_emit      = r_emit + CW'(1);
                    end else begin
                        n_out_valid = 1'b0;
                        n_state     = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_pending   <= '0;
            r_emit      <= '0;
            r_last_t    <= '0;
            r_err       <= '0;
            r_gap_fail  <= 1'b0;
            r_out_valid <= 1'b0;
            r_interval  <= 16'd625;
            r_tolerance <= 16'd125;
            r_future    <= 20'd5000;
            r_stale     <= 27'd1000000;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pending   <= n_pending;
            r_emit      <= n_emit;
            r_last_t    <= n_last_t;
            r_err       <= n_err;
            r_gap_fail  <= n_gap_fail;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_INTERVAL:  r_interval  <= i_cfg_data[15:0];
                    CFG_TOLERANCE: r_tolerance <= i_cfg_data[15:0];
                    CFG_FUTURE:    r_future    <= i_cfg_data[19:0];
                    CFG_STALE:     r_stale     <= i_cfg_data[26:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_qd  <= n_qd;
        r_acc <= n_acc;
        if (in_acc) begin
            r_now <= i_now_us;
            r_smp <= '{accel_x: i_accel_x, accel_y: i_accel_y, accel_z: i_accel_z,
                       gyro_x: i_gyro_x, gyro_y: i_gyro_y, gyro_z: i_gyro_z};
        end
        if (store_we) begin
            r_store[wr_idx] <= r_smp;
        end
        if (out_load) begin
            r_o_scan <= r_store[r_emit[IW-1:0]];
            r_o_time <= NOW_W'(r_last_t);
            r_o_idx  <= 5'(r_emit);
            r_o_err  <= r_err;
            r_o_last <= (r_emit == CW'(BATCH_SIZE - 1));
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_accel_x   = r_o_scan.accel_x;
    assign o_out_accel_y   = r_o_scan.accel_y;
    assign o_out_accel_z   = r_o_scan.accel_z;
    assign o_out_gyro_x    = r_o_scan.gyro_x;
    assign o_out_gyro_y    = r_o_scan.gyro_y;
    assign o_out_gyro_z    = r_o_scan.gyro_z;
    assign o_batch_time_us = r_o_time;
    assign o_sample_index  = r_o_idx;
    assign o_batch_count   = 6'(BATCH_SIZE);
    assign o_error_total   = r_o_err;
    assign o_last          = r_o_last;

endmodule
`default_nettype wire

// File: src/isb_checker.sv
// Port-level checker for the scan batcher, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "imu_scan_batcher_unit_macros.svh"
module isb_checker (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               o_in_stall,
    input wire               o_out_valid,
    input wire               i_out_stall,
    input wire signed [15:0] o_out_accel_x,
    input wire [62:0]        o_batch_time_us,
    input wire [4:0]         o_sample_index,
    input wire [5:0]         o_batch_count,
    input wire               o_last
);

    logic [83:0] out_word;
    logic [4:0]  idx_succ;

    assign out_word = {o_out_accel_x, o_sample_index, o_batch_time_us};
    assign idx_succ = o_sample_index + 5'd1;

    `ISB_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(out_word))
    `ISB_ASSERT_NOW(a_no_req_while_emit, o_out_valid, o_in_stall)
    `ISB_ASSERT_NEXT(a_last_ends_batch, o_out_valid && o_last && !i_out_stall, !o_out_valid)
    `ISB_ASSERT_NEXT(a_index_steps, o_out_valid && !o_last && !i_out_stall, o_out_valid && (o_sample_index == $past(idx_succ)))
    `ISB_ASSERT_NOW(a_index_in_batch, o_out_valid, o_sample_index < o_batch_count)

endmodule

bind imu_scan_batcher_unit isb_checker u_isb_checker (.*);
`default_nettype wire

// File: verif/imu_scan_batcher_unit_test.sv
// Self-checking bench for the IMU scan batcher: directed stamp cases, random scan streams, hold-off.
`timescale 1ns / 1ps
module imu_scan_batcher_unit_test;
    import isb_pkg::*;

    localparam int BATCH = 2;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 150;
    localparam int HOLD_CYCLES = 400;
    localparam logic [63:0] MASK63 = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        t_scan            axes;
        logic [63:0]      stamp_ns;
        logic [NOW_W-1:0] now_us;
    } scan_t;

    typedef struct packed {
        t_scan            axes;
        logic [NOW_W-1:0] batch_time_us;
        logic [4:0]       sample_index;
        logic [5:0]       batch_count;
        logic [31:0]      error_total;
        logic             last;
    } sample_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [1:0]          i_cfg_index = CFG_INTERVAL;
    logic [CFG_W-1:0]    i_cfg_data = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic signed [15:0]  i_accel_x = '0;
    logic signed [15:0]  i_accel_y = '0;
    logic signed [15:0]  i_accel_z = '0;
    logic signed [15:0]  i_gyro_x = '0;
    logic signed [15:0]  i_gyro_y = '0;
    logic signed [15:0]  i_gyro_z = '0;
    logic signed [63:0]  i_stamp_ns = '0;
    logic [NOW_W-1:0]    i_now_us = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic signed [15:0]  o_out_accel_x;
    logic signed [15:0]  o_out_accel_y;
    logic signed [15:0]  o_out_accel_z;
    logic signed [15:0]  o_out_gyro_x;
    logic signed [15:0]  o_out_gyro_y;
    logic signed [15:0]  o_out_gyro_z;
    logic [NOW_W-1:0]    o_batch_time_us;
    logic [4:0]          o_sample_index;
    logic [5:0]          o_batch_count;
    logic [31:0]         o_error_total;
    logic                o_last;

    // expected batch samples, oldest first
    sample_t due_samples[$];

    logic [63:0] interval_us = 64'd625;
    logic [63:0] tolerance_us = 64'd125;
    logic [63:0] lead_us = 64'd5000;
    logic [63:0] lag_us = 64'd1000000;
    int          held_count = 0;
    t_scan       held_axes[BATCH];
    logic [63:0] prev_time_us = '0;
    logic [31:0] err_total = '0;

    logic [63:0] clock_us = '0;
    int fail_count = 0;
    int scans_sent = 0;
    int samples_seen = 0;
    int configs_applied = 0;
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    bit hold_off_req = 1'b0;

    imu_scan_batcher_unit #(
        .BATCH_SIZE(BATCH)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_accel_x      (i_accel_x),
        .i_accel_y      (i_accel_y),
        .i_accel_z      (i_accel_z),
        .i_gyro_x       (i_gyro_x),
        .i_gyro_y       (i_gyro_y),
        .i_gyro_z       (i_gyro_z),
        .i_stamp_ns     (i_stamp_ns),
        .i_now_us       (i_now_us),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_accel_x  (o_out_accel_x),
        .o_out_accel_y  (o_out_accel_y),
        .o_out_accel_z  (o_out_accel_z),
        .o_out_gyro_x   (o_out_gyro_x),
        .o_out_gyro_y   (o_out_gyro_y),
        .o_out_gyro_z   (o_out_gyro_z),
        .o_batch_time_us(o_batch_time_us),
        .o_sample_index (o_sample_index),
        .o_batch_count  (o_batch_count),
        .o_error_total  (o_error_total),
        .o_last         (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function void note_error();
        if (err_total != 32'hFFFF_FFFF) err_total++;
    endfunction

    task automatic batch_scan(input scan_t s);
        logic [63:0] t;
        logic [63:0] now;
        longint      delta;
        longint      lo;
        longint      hi;
        sample_t     smp;
        if (s.stamp_ns == 64'd0 || s.stamp_ns[63]) begin
            note_error();
            held_count = 0;
            return;
        end
        t = s.stamp_ns / 64'd1000;
        now = {1'b0, s.now_us};
        if (t > now + lead_us || now > t + lag_us) begin
            note_error();
            held_count = 0;
            prev_time_us = t;
            return;
        end
        if (prev_time_us != 64'd0) begin
            delta = longint'(t) - longint'(prev_time_us & MASK63);
            lo = longint'(interval_us) - longint'(tolerance_us);
            hi = longint'(interval_us) + longint'(tolerance_us);
            if (delta < lo || delta > hi) begin
                note_error();
                held_count = 0;
            end
        end
        if (held_count >= BATCH) begin
            note_error();
            held_count = 0;
        end
        held_axes[held_count] = s.axes;
        held_count++;
        prev_time_us = t;
        if (held_count == BATCH) begin
            for (int k = 0; k < BATCH; k++) begin
                smp.axes = held_axes[k];
                smp.batch_time_us = t[NOW_W-1:0];
                smp.sample_index = 5'(k);
                smp.batch_count = 6'(BATCH);
                smp.error_total = err_total;
                smp.last = (k == BATCH - 1);
                due_samples.push_back(smp);
            end
            held_count = 0;
        end
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [63:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val[CFG_W-1:0];
        @(posedge i_clk);
        case (idx)
            CFG_INTERVAL:  interval_us = val & 64'hFFFF;
            CFG_TOLERANCE: tolerance_us = val & 64'hFFFF;
            CFG_FUTURE:    lead_us = val & 64'hF_FFFF;
            CFG_STALE:     lag_us = val & 64'h7FF_FFFF;
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [63:0] ivl, input logic [63:0] tol,
                                input logic [63:0] lead, input logic [63:0] lag);
        i_cfg_we <= 1'b1;
        put_reg(CFG_INTERVAL, ivl);
        put_reg(CFG_TOLERANCE, tol);
        put_reg(CFG_FUTURE, lead);
        put_reg(CFG_STALE, lag);
        i_cfg_we <= 1'b0;
        configs_applied++;
    endtask

    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        while (due_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_scan(input scan_t s);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_accel_x <= s.axes.accel_x;
        i_accel_y <= s.axes.accel_y;
        i_accel_z <= s.axes.accel_z;
        i_gyro_x <= s.axes.gyro_x;
        i_gyro_y <= s.axes.gyro_y;
        i_gyro_z <= s.axes.gyro_z;
        i_stamp_ns <= s.stamp_ns;
        i_now_us <= s.now_us;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        batch_scan(s);
        scans_sent++;
    endtask

    function automatic scan_t at_time(input logic [63:0] stamp, input logic [63:0] now);
        scan_t s;
        s.axes = {$urandom, $urandom, $urandom};
        s.stamp_ns = stamp;
        s.now_us = now[NOW_W-1:0];
        return s;
    endfunction

    task automatic send_us(input logic [63:0] t, input logic [63:0] now);
        send_scan(at_time(t * 64'd1000 + 64'($urandom_range(0, 999)), now));
    endtask

    task automatic test_first_batch();
        scan_t s;
        clock_us = 64'd1_000_000_000;
        s = at_time(clock_us * 64'd1000, clock_us);
        s.axes = {6{16'h7FFF}};
        send_scan(s);
        clock_us += 64'd625;
        s = at_time(clock_us * 64'd1000 + 64'd999, clock_us);
        s.axes = {6{16'h8000}};
        send_scan(s);
    endtask

    task automatic test_bad_stamps();
        send_scan(at_time(64'd0, clock_us));
        send_scan(at_time(64'hFFFF_FFFF_FFFF_FFFF, clock_us));
        send_scan(at_time(64'h8000_0000_0000_0000, clock_us));
        // sub-microsecond stamp truncates to zero: the next scan sees no previous time
        send_scan(at_time(64'd999, 64'd0));
        clock_us = 64'd2_000_000;
        send_us(clock_us, clock_us);
    endtask

    task automatic test_window_edges();
        clock_us += 64'd625;
        send_us(clock_us, clock_us - 64'd5000);
        clock_us += 64'd625;
        send_us(clock_us, clock_us - 64'd5001);
        clock_us += 64'd625;
        send_us(clock_us, clock_us + 64'd1_000_000);
        clock_us += 64'd625;
        send_us(clock_us, clock_us + 64'd1_000_001);
    endtask

    task automatic test_interval_edges();
        clock_us += 64'd500;
        send_us(clock_us, clock_us);
        clock_us += 64'd750;
        send_us(clock_us, clock_us);
        clock_us += 64'd499;
        send_us(clock_us, clock_us);
        clock_us += 64'd751;
        send_us(clock_us, clock_us);
        clock_us += 64'd625;
        send_us(clock_us, clock_us);
    endtask

    task automatic test_extreme_stamps();
        send_scan(at_time(MASK63, MASK63));
        send_scan(at_time(MASK63, MASK63 / 64'd1000));
    endtask

    task automatic test_negative_lower_bound();
        drain_pipeline();
        apply_config(64'd10, 64'd100, 64'd5000, 64'd1_000_000);
        clock_us = 64'd3_000_000;
        send_us(clock_us, clock_us);
        clock_us -= 64'd50;
        send_us(clock_us, clock_us);
        clock_us -= 64'd91;
        send_us(clock_us, clock_us);
        clock_us += 64'd110;
        send_us(clock_us, clock_us);
    endtask

    // mostly regular scans; some interval breaks, window breaks and bad stamps
    task automatic run_scan_stream(input int n, input int steady_n);
        logic [63:0] t;
        logic [63:0] now;
        logic [63:0] bad;
        longint      step;
        int          kind;
        clock_us = ({$urandom, $urandom} & 64'h000F_FFFF_FFFF_FFFF) | 64'h1_0000_0000;
        for (int i = 0; i < n; i++) begin
            tx_steady = (i < steady_n);
            rx_steady = (i < steady_n);
            kind = $urandom_range(0, 99);
            if (kind >= 94) begin
                bad = ($urandom_range(0, 3) == 0) ? 64'd0 : {1'b1, 31'($urandom), 32'($urandom)};
                send_scan(at_time(bad, clock_us));
            end else begin
                step = longint'(interval_us) + longint'($urandom_range(0, 32'(2 * tolerance_us)))
                       - longint'(tolerance_us);
                if (kind >= 80 && kind < 88) begin
                    if ($urandom_range(0, 1))
                        step = longint'(interval_us) + longint'(tolerance_us) + 1
                               + longint'($urandom_range(0, 1000));
                    else
                        step = longint'(interval_us) - longint'(tolerance_us) - 1
                               - longint'($urandom_range(0, 1000));
                end
                t = clock_us + 64'(step);
                if (kind >= 88) begin
                    if ($urandom_range(0, 1))
                        now = t + lag_us + 64'd1 + 64'($urandom_range(0, 1000));
                    else
                        now = t - lead_us - 64'd1 - 64'($urandom_range(0, 1000));
                end else if ($urandom_range(0, 1)) begin
                    now = t + 64'($urandom_range(0, 32'(lag_us)));
                end else begin
                    now = t - 64'($urandom_range(0, 32'(lead_us)));
                end
                send_us(t, now);
                clock_us = t;
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_default_stream();
        drain_pipeline();
        apply_config(64'd625, 64'd125, 64'd5000, 64'd1_000_000);
        run_scan_stream(30, 12);
    endtask

    task automatic test_tight_stream();
        drain_pipeline();
        apply_config(64'd1, 64'd0, 64'd0, 64'd0);
        run_scan_stream(20, 0);
    endtask

    task automatic test_wide_stream();
        drain_pipeline();
        apply_config(64'd65535, 64'd65535, 64'd1_000_000, 64'd100_000_000);
        run_scan_stream(20, 0);
    endtask

    task automatic test_random_config_stream();
        drain_pipeline();
        apply_config(64'($urandom_range(1, 65535)), 64'($urandom_range(0, 65535)),
                     64'($urandom_range(0, 1_000_000)), 64'($urandom_range(0, 100_000_000)));
        run_scan_stream(20, 0);
    endtask

    // output side stops for a long stretch while regular scans keep coming
    task automatic test_output_hold_off();
        tx_steady = 1'b1;
        hold_off_req = 1'b1;
        for (int i = 0; i < 8; i++) begin
            clock_us += interval_us;
            send_us(clock_us, clock_us);
        end
        tx_steady = 1'b0;
    endtask

    initial begin : rx_side
        int hold;
        forever begin
            if (hold_off_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                hold = rx_steady ? 0 : $urandom_range(0, 6);
                if (hold > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (hold) @(posedge i_clk);
                end
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic flag(input string what, input logic [63:0] want, input logic [63:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s mismatch: expected %0h actual %0h", $time, what, want, got);
    endtask

    task automatic cmp(input string what, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) flag(what, want, got);
    endtask

    always @(posedge i_clk) begin
        sample_t want;
        sample_t got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.axes = {o_out_accel_x, o_out_accel_y, o_out_accel_z,
                        o_out_gyro_x, o_out_gyro_y, o_out_gyro_z};
            got.batch_time_us = o_batch_time_us;
            got.sample_index = o_sample_index;
            got.batch_count = o_batch_count;
            got.error_total = o_error_total;
            got.last = o_last;
            if (due_samples.size() == 0) begin
                flag("sample with nothing due, index", 64'd0, 64'(got.sample_index));
            end else begin
                want = due_samples.pop_front();
                cmp("accel_x", 64'(want.axes.accel_x), 64'(got.axes.accel_x));
                cmp("accel_y", 64'(want.axes.accel_y), 64'(got.axes.accel_y));
                cmp("accel_z", 64'(want.axes.accel_z), 64'(got.axes.accel_z));
                cmp("gyro_x", 64'(want.axes.gyro_x), 64'(got.axes.gyro_x));
                cmp("gyro_y", 64'(want.axes.gyro_y), 64'(got.axes.gyro_y));
                cmp("gyro_z", 64'(want.axes.gyro_z), 64'(got.axes.gyro_z));
                cmp("batch_time_us", 64'(want.batch_time_us), 64'(got.batch_time_us));
                cmp("sample_index", 64'(want.sample_index), 64'(got.sample_index));
                cmp("batch_count", 64'(want.batch_count), 64'(got.batch_count));
                cmp("error_total", 64'(want.error_total), 64'(got.error_total));
                cmp("last", 64'(want.last), 64'(got.last));
                samples_seen++;
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timeout after %0d cycles, %0d samples still due", cycles, due_samples.size());
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_first_batch();
        test_bad_stamps();
        test_window_edges();
        test_interval_edges();
        test_extreme_stamps();
        test_negative_lower_bound();
        test_default_stream();
        test_tight_stream();
        test_wide_stream();
        test_random_config_stream();
        test_output_hold_off();
        drain_pipeline();
        $display("Ran %0d scans under %0d register settings; %0d batch samples checked.",
                 scans_sent, configs_applied + 1, samples_seen);
        $display("Bad stamps, window and interval edges, negative lower bound, long hold-off.");
        if (fail_count == 0 && due_samples.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
